>>> rtl/csem_pkg.sv
package csem_pkg;

  // Sizes of the wait queue and of the requester ids.
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int USED_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Count field widths and APB port widths.
  localparam int CFG_BITS    = 16;
  localparam int COUNT_BITS  = 17;
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 3;

  // Register index decoded from paddr[2].
  localparam logic REG_INITIAL_COUNT = 1'b0;

  // Largest count that an up may reach.
  localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = 17'sd65535;

  // Request operations.
  typedef enum logic [1:0] {
    OP_DOWN     = 2'd0,
    OP_TRY_DOWN = 2'd1,
    OP_UP       = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  // Error codes of a result.
  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_QUEUE_FULL = 2'd1,
    ERR_SATURATED  = 2'd2
  } err_t;

  // Controller states: the result register is empty or holds a result.
  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

>>> rtl/counting_semaphore_wait_queue.sv
// Counting semaphore with a FIFO queue of waiting requester ids.
// Requests arrive on in_valid/in_stall with an operation (down, try down,
// up, query) and a requester id; each request gives exactly one result on
// out_valid/out_stall (granted, must_wait, wake_valid, wake_id, available,
// error_code, count_now). A request is taken when valid is high and stall is
// low at a rising clock edge.
// The result is in the result register the cycle after the request is taken.
// Throughput is one request per cycle while the receiver does not stall, set by the single
// count update and queue push or pop done in the cycle the request is taken.
// When the receiver stalls, the result is held and in_stall rises, so at most
// one result waits; requests resume as soon as the result is taken.
// Reset (rst, synchronous) sets the count to 1, empties the queue and the
// result register and sets initial_count to 1. The APB port at address 0
// holds initial_count; writing it loads the count when no requester waits.
// Write it only while no request is in flight.
module counting_semaphore_wait_queue
  import csem_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic [ID_BITS-1:0]           requester_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         granted,
  output logic                         must_wait,
  output logic                         wake_valid,
  output logic [ID_BITS-1:0]           wake_id,
  output logic                         available,
  output logic [1:0]                   error_code,
  output logic signed [COUNT_BITS-1:0] count_now,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [DATA_BITS-1:0]         pwdata,
  output logic [DATA_BITS-1:0]         prdata,
  output logic                         pready
);

  cmd_t cmd;

  assign pready = 1'b1;

  // Handshake controller.
  csem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Count, wait queue, result and configuration register.
  csem_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .operation    (operation),
    .requester_id (requester_id),
    .granted      (granted),
    .must_wait    (must_wait),
    .wake_valid   (wake_valid),
    .wake_id      (wake_id),
    .available    (available),
    .error_code   (error_code),
    .count_now    (count_now),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
  );

endmodule

>>> rtl/csem_ctrl.sv
module csem_ctrl
  import csem_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // Next state: a new request fills the result register, a taken result empties it.
  always_comb begin
    state_next = state;
    if (cmd.exec) begin
      state_next = ST_FULL;
    end else if (out_valid && !out_stall) begin
      state_next = ST_EMPTY;
    end
  end

  // Outputs: a request is taken unless a held result is stalled.
  always_comb begin
    out_valid = (state == ST_FULL);
    in_stall  = (state == ST_FULL) && out_stall;
    cmd.exec  = in_valid && !in_stall;
  end

`ifndef ASSERT_OFF
  // An accepted request shows a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst) cmd.exec |=> out_valid)
    else $error("accepted request produced no result");

  // The input side is only stalled while a result is held.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("input stalled with no result held");
`endif

endmodule

>>> rtl/csem_datapath.sv
module csem_datapath
  import csem_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  input  logic [1:0]                   operation,
  input  logic [ID_BITS-1:0]           requester_id,
  output logic                         granted,
  output logic                         must_wait,
  output logic                         wake_valid,
  output logic [ID_BITS-1:0]           wake_id,
  output logic                         available,
  output logic [1:0]                   error_code,
  output logic signed [COUNT_BITS-1:0] count_now,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [DATA_BITS-1:0]         pwdata,
  output logic [DATA_BITS-1:0]         prdata
);

  // Semaphore state.
  logic [CFG_BITS-1:0]          initial_count;
  logic signed [COUNT_BITS-1:0] count;
  logic [ID_BITS-1:0]           waiters [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]          head;
  logic [PTR_BITS-1:0]          tail;
  logic [USED_BITS-1:0]         used;

  // Values computed for the request being accepted.
  logic signed [COUNT_BITS-1:0] count_next;
  logic signed [COUNT_BITS-1:0] count_dec;
  logic signed [COUNT_BITS-1:0] count_inc;
  logic                         push;
  logic                         pop;
  logic                         res_granted;
  logic                         res_must_wait;
  err_t                         res_err;
  logic                         cfg_write;
  op_t                          op;

  assign op        = op_t'(operation);
  assign count_dec = count - 17'sd1;
  assign count_inc = count + 17'sd1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_INITIAL_COUNT);

  // Register read.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_INITIAL_COUNT) begin
      prdata = {{(DATA_BITS - CFG_BITS){1'b0}}, initial_count};
    end
  end

  // Decide the effect of one request on the count and the wait queue.
  always_comb begin
    count_next    = count;
    push          = 1'b0;
    pop           = 1'b0;
    res_granted   = 1'b0;
    res_must_wait = 1'b0;
    res_err       = ERR_NONE;
    unique case (op)
      OP_DOWN: begin
        if (count_dec >= 17'sd0) begin
          count_next  = count_dec;
          res_granted = 1'b1;
        end else if (used >= USED_BITS'(QUEUE_DEPTH)) begin
          res_err = ERR_QUEUE_FULL;
        end else begin
          count_next    = count_dec;
          push          = 1'b1;
          res_must_wait = 1'b1;
        end
      end
      OP_TRY_DOWN: begin
        if (count > 17'sd0) begin
          count_next  = count_dec;
          res_granted = 1'b1;
        end
      end
      OP_UP: begin
        if (count >= COUNT_MAX) begin
          res_err = ERR_SATURATED;
        end else begin
          count_next  = count_inc;
          res_granted = 1'b1;
          pop         = (count_inc <= 17'sd0) && (used != '0);
        end
      end
      OP_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  // Control state: count, queue pointers and the configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_count <= CFG_BITS'(1);
      count         <= 17'sd1;
      head          <= '0;
      tail          <= '0;
      used          <= '0;
    end else if (cfg_write) begin
      initial_count <= pwdata[CFG_BITS-1:0];
      if (used == '0) begin
        count <= $signed({1'b0, pwdata[CFG_BITS-1:0]});
      end
    end else if (cmd.exec) begin
      count <= count_next;
      if (push) begin
        tail <= (tail == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
        used <= used + 1'b1;
      end
      if (pop) begin
        head <= (head == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
        used <= used - 1'b1;
      end
    end
  end

  // Waiter ids, written at the tail.
  always_ff @(posedge clk) begin
    if (cmd.exec && push) begin
      waiters[tail] <= requester_id;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      granted    <= res_granted;
      must_wait  <= res_must_wait;
      wake_valid <= pop;
      wake_id    <= pop ? waiters[head] : '0;
      available  <= (count_next > 17'sd0);
      error_code <= res_err;
      count_now  <= count_next;
    end
  end

`ifndef ASSERT_OFF
  // An empty queue means the count is not negative.
  assert property (@(posedge clk) disable iff (rst) (used == '0) |-> (count >= 17'sd0))
    else $error("empty wait queue with negative count");

  // The magnitude of a negative count equals the number of waiters.
  assert property (@(posedge clk) disable iff (rst)
      (count < 17'sd0) |-> ($signed({{(COUNT_BITS - USED_BITS){1'b0}}, used}) == -count))
    else $error("waiter count does not match semaphore count");

  // A wake comes only from a completed up.
  assert property (@(posedge clk) disable iff (rst) $past(cmd.exec) && wake_valid |-> granted)
    else $error("wake reported without a completed up");
`endif

endmodule
